// ===== sv/ucee_pkg.sv =====
// ----------------------------------------------------------------------------
// ucee_pkg
// Shared types, codes and helpers of the endpoint-zero control engine.
// ----------------------------------------------------------------------------
package ucee_pkg;

   // largest control IN packet, and the width that holds 0..MAX_PACKET
   localparam int MAX_PACKET   = 64;
   localparam int PKT_LEN_W    = $clog2(MAX_PACKET + 1);
   localparam int STRING_SLOTS = 4;
   localparam int STR_SEL_W    = 2;

   // command queue between decode and execute
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // register reset values
   localparam logic [7:0]  DEVICE_DESC_LEN_RST = 8'd18;
   localparam logic [15:0] CONFIG_DESC_LEN_RST = 16'd67;
   localparam logic [2:0]  STRING_COUNT_RST    = 3'd4;
   localparam logic [7:0]  STRING_LEN_RST      = 8'd4;

   // setup decode constants
   localparam logic [1:0] KIND_STANDARD       = 2'b00;
   localparam logic [1:0] KIND_CLASS          = 2'b01;
   localparam logic [7:0] REQ_GET_DESCRIPTOR  = 8'h06;
   localparam logic [7:0] REQ_SET_ADDRESS     = 8'h05;
   localparam logic [7:0] REQ_SET_CONFIG      = 8'h09;
   localparam logic [7:0] REQ_SET_LINE_CODING = 8'h20;
   localparam logic [7:0] REQ_GET_LINE_CODING = 8'h21;
   localparam logic [7:0] REQ_SET_CTRL_LINE   = 8'h22;
   localparam logic [7:0] DESC_DEVICE         = 8'h01;
   localparam logic [7:0] DESC_CONFIG         = 8'h02;
   localparam logic [7:0] DESC_STRING         = 8'h03;
   localparam logic [7:0] DESC_QUALIFIER      = 8'h06;
   localparam logic [15:0] LINE_CODING_LEN    = 16'd7;

   typedef enum logic [1:0] {
      EVT_SETUP     = 2'd0,
      EVT_IN_DONE   = 2'd1,
      EVT_BUS_RESET = 2'd2
   } event_type;

   typedef enum logic [2:0] {
      CSR_DEVICE_DESC_LEN = 3'd0,
      CSR_CONFIG_DESC_LEN = 3'd1,
      CSR_STRING_COUNT    = 3'd2,
      CSR_STRING_LEN_A    = 3'd3,
      CSR_STRING_LEN_B    = 3'd4,
      CSR_STRING_LEN_C    = 3'd5,
      CSR_STRING_LEN_D    = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ACTION_NONE      = 3'd0,
      ACTION_SEND_IN   = 3'd1,
      ACTION_STALL     = 3'd2,
      ACTION_ARM_OUT   = 3'd3,
      ACTION_ARM_SETUP = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      SRC_ZLP         = 3'd0,
      SRC_DEVICE      = 3'd1,
      SRC_CONFIG      = 3'd2,
      SRC_STRING      = 3'd3,
      SRC_LINE_CODING = 3'd4
   } source_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_SEND = 2'd1,
      PH_RECV = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      DEV_DEFAULT    = 2'd0,
      DEV_ADDRESSED  = 2'd1,
      DEV_CONFIGURED = 2'd2
   } dev_state_type;

   typedef enum logic [1:0] {
      CMD_NOP       = 2'd0,
      CMD_SETUP     = 2'd1,
      CMD_IN_DONE   = 2'd2,
      CMD_BUS_RESET = 2'd3
   } cmd_op_type;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_SEND    = 2'd1,
      ACT_STALL   = 2'd2,
      ACT_ARM_OUT = 2'd3
   } setup_act_type;

   // classified command handed from decode to execute
   typedef struct packed {
      cmd_op_type    op;
      setup_act_type act;
      source_type    source;
      logic [7:0]    str_idx;
      logic [15:0]   send_len;
      logic          set_addr;
      logic          set_cfg;
      logic          set_line;
      logic [6:0]    addr;
      logic [1:0]    line;
   } cmd_type;

   // clamp a byte count to one packet
   function automatic logic [PKT_LEN_W-1:0] clamp_packet(input logic [15:0] len);
      logic [PKT_LEN_W-1:0] res;
      if (len < 16'(MAX_PACKET)) begin
         res = len[PKT_LEN_W-1:0];
      end else begin
         res = PKT_LEN_W'(MAX_PACKET);
      end
      return res;
   endfunction

endpackage

// ===== sv/ucee_req_if.sv =====
// ----------------------------------------------------------------------------
// ucee_req_if
// Event channel into the control engine: valid/ready plus setup fields.
// ----------------------------------------------------------------------------
interface ucee_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [7:0]  request_kind;
   logic [7:0]  request_code;
   logic [15:0] request_value;
   logic [15:0] request_length;

   modport source (output valid, event_kind, request_kind, request_code,
                   request_value, request_length, input ready);
   modport sink (input valid, event_kind, request_kind, request_code,
                 request_value, request_length, output ready);
endinterface

// ===== sv/ucee_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ucee_rsp_if
// Result channel out of the control engine: valid/ready plus action fields.
// ----------------------------------------------------------------------------
interface ucee_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [2:0]  data_source;
   logic [7:0]  string_index;
   logic [15:0] data_offset;
   logic [6:0]  packet_len;
   logic [6:0]  device_address;
   logic [1:0]  device_state;
   logic        configured;
   logic        dtr;
   logic        rts;

   modport source (output valid, action, data_source, string_index, data_offset,
                   packet_len, device_address, device_state, configured, dtr,
                   rts, input ready);
   modport sink (input valid, action, data_source, string_index, data_offset,
                 packet_len, device_address, device_state, configured, dtr,
                 rts, output ready);
endinterface

// ===== sv/usb_control_endpoint_engine_core.sv =====
// ----------------------------------------------------------------------------
// usb_control_endpoint_engine_core
// Endpoint-zero request handler: decodes setup, IN-complete and bus-reset
// events and issues one action beat per event.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one event per beat (setup fields, IN complete, bus
//   reset); rsp_chan returns exactly one result beat per event, in order.
//   csr_we/csr_index/csr_wdata load the descriptor lengths and string count;
//   write them only while no event is in flight.
//   An accepted event passes decode, one queue slot and execute into the
//   output register, which then holds its result beat. Throughput: one event
//   per cycle while rsp_chan is not stalled, set by the single execute stage
//   that updates the control state as it takes each command.
//   The two-entry command queue and the output register let the input side
//   keep accepting while a result waits; when rsp_chan stalls, the queue
//   fills and req_chan.ready drops after two more events.
//   Reset (synchronous, active high) empties the queue, drops rsp_chan.valid,
//   returns the descriptor registers to their defaults and clears address,
//   configuration, line state and the control phase.
// ----------------------------------------------------------------------------
module usb_control_endpoint_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   ucee_req_if.sink    req_chan,
   ucee_rsp_if.source  rsp_chan
);

   ucee_pkg::cmd_type  dec_cmd;
   ucee_pkg::cmd_type  head_cmd;
   logic               dec_push;
   logic               q_not_full;
   logic               q_not_empty;
   logic               q_pop;

   assign req_chan.ready = q_not_full;

   // event decode and descriptor registers
   ucee_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .evt_valid  (req_chan.valid),
      .evt_type   (req_chan.event_kind),
      .evt_kind   (req_chan.request_kind),
      .evt_code   (req_chan.request_code),
      .evt_value  (req_chan.request_value),
      .evt_length (req_chan.request_length),
      .cmd        (dec_cmd),
      .cmd_push   (dec_push)
   );

   // command queue
   ucee_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (dec_push),
      .push_cmd  (dec_cmd),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .head_cmd  (head_cmd),
      .not_empty (q_not_empty)
   );

   // execution and result register
   ucee_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_not_empty),
      .cmd       (head_cmd),
      .cmd_pop   (q_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== sv/ucee_front.sv =====
// ----------------------------------------------------------------------------
// ucee_front
// Holds the descriptor registers and classifies each event into a command.
// ----------------------------------------------------------------------------
module ucee_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               evt_valid,
   input  logic [1:0]         evt_type,
   input  logic [7:0]         evt_kind,
   input  logic [7:0]         evt_code,
   input  logic [15:0]        evt_value,
   input  logic [15:0]        evt_length,
   output ucee_pkg::cmd_type  cmd,
   output logic               cmd_push
);

   logic [7:0]  dev_len_ff;
   logic [15:0] cfg_len_ff;
   logic [2:0]  str_count_ff;
   logic [7:0]  str_len_ff [ucee_pkg::STRING_SLOTS];

   logic [7:0]  dtype;
   logic [7:0]  idx;
   logic        idx_ok;
   logic [7:0]  sel_len;

   // descriptor registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_len_ff   <= ucee_pkg::DEVICE_DESC_LEN_RST;
         cfg_len_ff   <= ucee_pkg::CONFIG_DESC_LEN_RST;
         str_count_ff <= ucee_pkg::STRING_COUNT_RST;
         for (int i = 0; i < ucee_pkg::STRING_SLOTS; i++) begin
            str_len_ff[i] <= ucee_pkg::STRING_LEN_RST;
         end
      end else if (csr_we) begin
         case (csr_index)
            ucee_pkg::CSR_DEVICE_DESC_LEN: dev_len_ff   <= csr_wdata[7:0];
            ucee_pkg::CSR_CONFIG_DESC_LEN: cfg_len_ff   <= csr_wdata;
            ucee_pkg::CSR_STRING_COUNT:    str_count_ff <= csr_wdata[2:0];
            ucee_pkg::CSR_STRING_LEN_A:    str_len_ff[0] <= csr_wdata[7:0];
            ucee_pkg::CSR_STRING_LEN_B:    str_len_ff[1] <= csr_wdata[7:0];
            ucee_pkg::CSR_STRING_LEN_C:    str_len_ff[2] <= csr_wdata[7:0];
            ucee_pkg::CSR_STRING_LEN_D:    str_len_ff[3] <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // string descriptor lookup
   assign dtype   = evt_value[15:8];
   assign idx     = evt_value[7:0];
   assign idx_ok  = (idx < {5'd0, str_count_ff}) && (idx < 8'(ucee_pkg::STRING_SLOTS));
   assign sel_len = str_len_ff[idx[ucee_pkg::STR_SEL_W-1:0]];

   // event classification
   always_comb begin
      cmd          = '0;
      cmd.op       = ucee_pkg::CMD_NOP;
      cmd.act      = ucee_pkg::ACT_NONE;
      cmd.source   = ucee_pkg::SRC_ZLP;
      cmd.addr     = evt_value[6:0];
      cmd.line     = evt_value[1:0];
      case (evt_type)
         ucee_pkg::EVT_SETUP: begin
            cmd.op = ucee_pkg::CMD_SETUP;
            if (evt_kind[6:5] == ucee_pkg::KIND_STANDARD) begin
               cmd.act = ucee_pkg::ACT_SEND;
               if (evt_code == ucee_pkg::REQ_GET_DESCRIPTOR) begin
                  if (dtype == ucee_pkg::DESC_DEVICE) begin
                     cmd.source   = ucee_pkg::SRC_DEVICE;
                     cmd.send_len = (evt_length < {8'd0, dev_len_ff}) ?
                                    evt_length : {8'd0, dev_len_ff};
                  end else if (dtype == ucee_pkg::DESC_CONFIG) begin
                     cmd.source   = ucee_pkg::SRC_CONFIG;
                     cmd.send_len = (evt_length < cfg_len_ff) ? evt_length : cfg_len_ff;
                  end else if (dtype == ucee_pkg::DESC_STRING && idx_ok) begin
                     cmd.source   = ucee_pkg::SRC_STRING;
                     cmd.str_idx  = idx;
                     cmd.send_len = (evt_length < {8'd0, sel_len}) ?
                                    evt_length : {8'd0, sel_len};
                  end else if (dtype == ucee_pkg::DESC_QUALIFIER) begin
                     cmd.act = ucee_pkg::ACT_STALL;
                  end else begin
                     cmd.act = ucee_pkg::ACT_NONE;
                  end
               end else if (evt_code == ucee_pkg::REQ_SET_ADDRESS) begin
                  cmd.set_addr = 1'b1;
               end else if (evt_code == ucee_pkg::REQ_SET_CONFIG) begin
                  cmd.set_cfg = 1'b1;
               end
            end else if (evt_kind[6:5] == ucee_pkg::KIND_CLASS) begin
               cmd.act = ucee_pkg::ACT_SEND;
               if (evt_code == ucee_pkg::REQ_SET_LINE_CODING) begin
                  cmd.act = ucee_pkg::ACT_ARM_OUT;
               end else if (evt_code == ucee_pkg::REQ_GET_LINE_CODING) begin
                  cmd.source   = ucee_pkg::SRC_LINE_CODING;
                  cmd.send_len = ucee_pkg::LINE_CODING_LEN;
               end else if (evt_code == ucee_pkg::REQ_SET_CTRL_LINE) begin
                  cmd.set_line = 1'b1;
               end
            end
         end
         ucee_pkg::EVT_IN_DONE:   cmd.op = ucee_pkg::CMD_IN_DONE;
         ucee_pkg::EVT_BUS_RESET: cmd.op = ucee_pkg::CMD_BUS_RESET;
         default:                 cmd.op = ucee_pkg::CMD_NOP;
      endcase
   end

   assign cmd_push = evt_valid;

endmodule

// ===== sv/ucee_queue.sv =====
// ----------------------------------------------------------------------------
// ucee_queue
// Short command queue between event decode and execution.
// ----------------------------------------------------------------------------
module ucee_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ucee_pkg::cmd_type  push_cmd,
   output logic               not_full,
   input  logic               pop,
   output ucee_pkg::cmd_type  head_cmd,
   output logic               not_empty
);

   ucee_pkg::cmd_type                  mem_ff [ucee_pkg::QUEUE_DEPTH];
   logic [ucee_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ucee_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ucee_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   assign not_full  = count_ff != ucee_pkg::QUEUE_CNT_W'(ucee_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign head_cmd  = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ucee_pkg::QUEUE_PTR_W'(ucee_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ucee_pkg::QUEUE_PTR_W'(ucee_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/ucee_back.sv =====
// ----------------------------------------------------------------------------
// ucee_back
// Executes commands against the control and enumeration state and
// registers one result beat per command.
// ----------------------------------------------------------------------------
module ucee_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  ucee_pkg::cmd_type  cmd,
   output logic               cmd_pop,
   ucee_rsp_if.source         rsp_chan
);

   ucee_pkg::phase_type      phase_ff, phase_in;
   logic [15:0]              total_ff, total_in;
   logic [15:0]              sent_ff, sent_in;
   ucee_pkg::source_type     src_ff, src_in;
   logic [7:0]               str_ff, str_in;
   ucee_pkg::dev_state_type  dev_ff, dev_in;
   logic [6:0]               addr_ff, addr_in;
   logic                     cfg_ff, cfg_in;
   logic [1:0]               line_ff, line_in;

   logic                     out_valid_ff;
   ucee_pkg::action_type     act_ff, act_in;
   ucee_pkg::source_type     osrc_ff, osrc_in;
   logic [7:0]               ostr_ff, ostr_in;
   logic [15:0]              ooff_ff, ooff_in;
   logic [ucee_pkg::PKT_LEN_W-1:0] olen_ff, olen_in;

   logic [15:0]              left;
   logic [ucee_pkg::PKT_LEN_W-1:0] chunk;
   logic [15:0]              sent_next;
   logic [15:0]              remaining;

   // take a command when the output register is free or draining
   assign cmd_pop = cmd_valid && (!out_valid_ff || rsp_chan.ready);

   // chunk bookkeeping for IN complete
   assign left      = total_ff - sent_ff;
   assign chunk     = ucee_pkg::clamp_packet(left);
   assign sent_next = sent_ff + 16'(chunk);
   assign remaining = left - 16'(chunk);

   // command execution
   always_comb begin
      phase_in = phase_ff;
      total_in = total_ff;
      sent_in  = sent_ff;
      src_in   = src_ff;
      str_in   = str_ff;
      dev_in   = dev_ff;
      addr_in  = addr_ff;
      cfg_in   = cfg_ff;
      line_in  = line_ff;
      act_in   = ucee_pkg::ACTION_NONE;
      osrc_in  = ucee_pkg::SRC_ZLP;
      ostr_in  = '0;
      ooff_in  = '0;
      olen_in  = '0;
      case (cmd.op)
         ucee_pkg::CMD_SETUP: begin
            if (phase_ff != ucee_pkg::PH_SEND) begin
               phase_in = ucee_pkg::PH_IDLE;
            end
            if (cmd.set_addr) begin
               addr_in = cmd.addr;
               dev_in  = (cmd.addr != '0) ? ucee_pkg::DEV_ADDRESSED : ucee_pkg::DEV_DEFAULT;
            end
            if (cmd.set_cfg) begin
               cfg_in = 1'b1;
               dev_in = ucee_pkg::DEV_CONFIGURED;
            end
            if (cmd.set_line) begin
               line_in = cmd.line;
            end
            case (cmd.act)
               ucee_pkg::ACT_SEND: begin
                  // a transfer already in its data phase swallows the new one
                  if (phase_ff != ucee_pkg::PH_SEND) begin
                     phase_in = ucee_pkg::PH_SEND;
                     total_in = cmd.send_len;
                     sent_in  = '0;
                     src_in   = cmd.source;
                     str_in   = cmd.str_idx;
                     act_in   = ucee_pkg::ACTION_SEND_IN;
                     osrc_in  = cmd.source;
                     ostr_in  = (cmd.source == ucee_pkg::SRC_STRING) ? cmd.str_idx : '0;
                     olen_in  = ucee_pkg::clamp_packet(cmd.send_len);
                  end
               end
               ucee_pkg::ACT_STALL: act_in = ucee_pkg::ACTION_STALL;
               ucee_pkg::ACT_ARM_OUT: begin
                  phase_in = ucee_pkg::PH_RECV;
                  act_in   = ucee_pkg::ACTION_ARM_OUT;
               end
               default: ;
            endcase
         end
         ucee_pkg::CMD_IN_DONE: begin
            if (phase_ff == ucee_pkg::PH_SEND && remaining != '0) begin
               sent_in = sent_next;
               act_in  = ucee_pkg::ACTION_SEND_IN;
               osrc_in = src_ff;
               ostr_in = (src_ff == ucee_pkg::SRC_STRING) ? str_ff : '0;
               ooff_in = sent_next;
               olen_in = ucee_pkg::clamp_packet(remaining);
            end else begin
               if (phase_ff == ucee_pkg::PH_SEND) begin
                  sent_in = sent_next;
               end
               phase_in = ucee_pkg::PH_IDLE;
               act_in   = ucee_pkg::ACTION_ARM_SETUP;
            end
         end
         ucee_pkg::CMD_BUS_RESET: begin
            dev_in   = ucee_pkg::DEV_DEFAULT;
            cfg_in   = 1'b0;
            addr_in  = '0;
            phase_in = ucee_pkg::PH_IDLE;
            act_in   = ucee_pkg::ACTION_ARM_SETUP;
         end
         default: ;
      endcase
   end

   // control and enumeration state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ucee_pkg::PH_IDLE;
         total_ff <= '0;
         sent_ff  <= '0;
         src_ff   <= ucee_pkg::SRC_ZLP;
         str_ff   <= '0;
         dev_ff   <= ucee_pkg::DEV_DEFAULT;
         addr_ff  <= '0;
         cfg_ff   <= 1'b0;
         line_ff  <= '0;
      end else if (cmd_pop) begin
         phase_ff <= phase_in;
         total_ff <= total_in;
         sent_ff  <= sent_in;
         src_ff   <= src_in;
         str_ff   <= str_in;
         dev_ff   <= dev_in;
         addr_ff  <= addr_in;
         cfg_ff   <= cfg_in;
         line_ff  <= line_in;
      end
   end

   // result beat valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd_pop) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result beat payload
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         act_ff  <= act_in;
         osrc_ff <= osrc_in;
         ostr_ff <= ostr_in;
         ooff_ff <= ooff_in;
         olen_ff <= olen_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.action         = act_ff;
   assign rsp_chan.data_source    = osrc_ff;
   assign rsp_chan.string_index   = ostr_ff;
   assign rsp_chan.data_offset    = ooff_ff;
   assign rsp_chan.packet_len     = olen_ff;
   assign rsp_chan.device_address = addr_ff;
   assign rsp_chan.device_state   = dev_ff;
   assign rsp_chan.configured     = cfg_ff;
   assign rsp_chan.dtr            = line_ff[0];
   assign rsp_chan.rts            = line_ff[1];

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the endpoint-zero control engine. A directed table
// walks every request, descriptor and event kind, then random control
// transfers (setup, IN chunks, status) mixed with noise run under several
// descriptor-length settings. Every result beat is checked field by field
// against a directed table value or an in-bench model of the engine.
// ----------------------------------------------------------------------------
module tb;
   import ucee_pkg::*;

   // event kind that the engine ignores
   localparam logic [1:0] EVT_UNUSED    = 2'd3;
   // request kinds outside standard and class
   localparam logic [1:0] KIND_VENDOR   = 2'b10;
   localparam logic [1:0] KIND_RESERVED = 2'b11;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  rkind;
      logic [7:0]  code;
      logic [15:0] value;
      logic [15:0] length;
   } ev_rec;

   typedef struct packed {
      action_type    act;
      source_type    src;
      logic [7:0]    str;
      logic [15:0]   off;
      logic [6:0]    len;
      logic [6:0]    addr;
      dev_state_type dstate;
      logic          cfg;
      logic          dtr;
      logic          rts;
   } action_rec;

   typedef struct packed {
      ev_rec     ev;
      logic      has_want;
      action_rec want;
   } dir_row;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   ucee_req_if req_bus ();
   ucee_rsp_if rsp_bus ();

   usb_control_endpoint_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   // model state
   phase_type     ctl_phase;
   logic [15:0]   xfer_total;
   logic [15:0]   xfer_sent;
   source_type    xfer_src;
   logic [7:0]    xfer_str;
   dev_state_type dev_state;
   logic [6:0]    dev_addr;
   logic          cfg_set;
   logic [15:0]   line_bits;

   // model copy of the descriptor registers
   logic [7:0]    dev_desc_len;
   logic [15:0]   cfg_desc_len;
   logic [2:0]    str_count;
   logic [7:0]    str_len [4];

   action_rec next_action;
   action_rec expected_actions [$];
   dir_row    directed_rows [$];

   int  mismatches;
   int  sent_items;
   int  checked_beats;
   int  action_seen [5];
   int  calm;
   bit  quiet_tail;

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
      return (a < b) ? a : b;
   endfunction

   // open a control IN transfer unless one is already going
   function automatic void begin_send(input source_type s, input logic [7:0] st,
                                      input logic [15:0] n);
      if (ctl_phase == PH_SEND) return;
      xfer_total = n;
      xfer_sent  = '0;
      ctl_phase  = PH_SEND;
      xfer_src   = s;
      xfer_str   = st;
      next_action.act = ACTION_SEND_IN;
      next_action.src = s;
      next_action.str = (s == SRC_STRING) ? st : 8'd0;
      next_action.off = '0;
      next_action.len = 7'(min16(n, 16'(MAX_PACKET)));
   endfunction

   // engine behavior for one event; updates model state
   function automatic action_rec ep0_respond(input ev_rec ev);
      logic [7:0]  dtype;
      logic [7:0]  idx;
      logic [15:0] left;
      logic [15:0] rem;
      next_action = '0;
      case (ev.kind)
         EVT_SETUP: begin
            if (ctl_phase != PH_SEND) ctl_phase = PH_IDLE;
            if (ev.rkind[6:5] == KIND_STANDARD) begin
               if (ev.code == REQ_GET_DESCRIPTOR) begin
                  dtype = ev.value[15:8];
                  idx   = ev.value[7:0];
                  if (dtype == DESC_DEVICE) begin
                     begin_send(SRC_DEVICE, 8'd0, min16(ev.length, {8'd0, dev_desc_len}));
                  end else if (dtype == DESC_CONFIG) begin
                     begin_send(SRC_CONFIG, 8'd0, min16(ev.length, cfg_desc_len));
                  end else if (dtype == DESC_STRING) begin
                     if (idx < {5'd0, str_count} && idx < STRING_SLOTS)
                        begin_send(SRC_STRING, idx, min16(ev.length, {8'd0, str_len[idx[1:0]]}));
                  end else if (dtype == DESC_QUALIFIER) begin
                     next_action.act = ACTION_STALL;
                  end
               end else if (ev.code == REQ_SET_ADDRESS) begin
                  dev_addr  = ev.value[6:0];
                  dev_state = (dev_addr != 7'd0) ? DEV_ADDRESSED : DEV_DEFAULT;
                  begin_send(SRC_ZLP, 8'd0, 16'd0);
               end else if (ev.code == REQ_SET_CONFIG) begin
                  cfg_set   = 1'b1;
                  dev_state = DEV_CONFIGURED;
                  begin_send(SRC_ZLP, 8'd0, 16'd0);
               end else begin
                  begin_send(SRC_ZLP, 8'd0, 16'd0);
               end
            end else if (ev.rkind[6:5] == KIND_CLASS) begin
               if (ev.code == REQ_SET_LINE_CODING) begin
                  ctl_phase = PH_RECV;
                  next_action.act = ACTION_ARM_OUT;
               end else if (ev.code == REQ_GET_LINE_CODING) begin
                  begin_send(SRC_LINE_CODING, 8'd0, LINE_CODING_LEN);
               end else if (ev.code == REQ_SET_CTRL_LINE) begin
                  line_bits = ev.value;
                  begin_send(SRC_ZLP, 8'd0, 16'd0);
               end else begin
                  begin_send(SRC_ZLP, 8'd0, 16'd0);
               end
            end
         end
         EVT_IN_DONE: begin
            rem = '0;
            if (ctl_phase == PH_SEND) begin
               left      = xfer_total - xfer_sent;
               xfer_sent = xfer_sent + min16(left, 16'(MAX_PACKET));
               rem       = xfer_total - xfer_sent;
            end
            if (rem != 16'd0) begin
               next_action.act = ACTION_SEND_IN;
               next_action.src = xfer_src;
               next_action.str = (xfer_src == SRC_STRING) ? xfer_str : 8'd0;
               next_action.off = xfer_sent;
               next_action.len = 7'(min16(rem, 16'(MAX_PACKET)));
            end else begin
               ctl_phase = PH_IDLE;
               next_action.act = ACTION_ARM_SETUP;
            end
         end
         EVT_BUS_RESET: begin
            dev_state = DEV_DEFAULT;
            cfg_set   = 1'b0;
            dev_addr  = '0;
            ctl_phase = PH_IDLE;
            next_action.act = ACTION_ARM_SETUP;
         end
         default: ;
      endcase
      next_action.addr   = dev_addr;
      next_action.dstate = dev_state;
      next_action.cfg    = cfg_set;
      next_action.dtr    = line_bits[0];
      next_action.rts    = line_bits[1];
      return next_action;
   endfunction

   function automatic ev_rec ev_of(input logic [1:0] k, input logic [7:0] rk,
                                   input logic [7:0] c, input logic [15:0] v,
                                   input logic [15:0] l);
      ev_rec e;
      e.kind = k; e.rkind = rk; e.code = c; e.value = v; e.length = l;
      return e;
   endfunction

   function automatic action_rec act_of(input action_type a, input source_type s,
                                        input logic [7:0] st, input logic [15:0] off,
                                        input logic [6:0] n, input logic [6:0] ad,
                                        input dev_state_type ds, input logic cf,
                                        input logic d, input logic r);
      action_rec x;
      x.act = a; x.src = s; x.str = st; x.off = off; x.len = n;
      x.addr = ad; x.dstate = ds; x.cfg = cf; x.dtr = d; x.rts = r;
      return x;
   endfunction

   function automatic ev_rec random_event(input logic [1:0] k);
      ev_rec e;
      e = ev_of(k, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      return e;
   endfunction

   // a meaningful setup with random content in the unused bits
   function automatic ev_rec pick_request();
      ev_rec      e;
      logic [7:0] dt;
      e = random_event(EVT_SETUP);
      e.length = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
      e.rkind[6:5] = KIND_STANDARD;
      case ($urandom_range(0, 10))
         0, 1, 2: begin
            e.code = REQ_GET_DESCRIPTOR;
            case ($urandom_range(0, 5))
               0:       dt = DESC_DEVICE;
               1:       dt = DESC_CONFIG;
               2, 3:    dt = DESC_STRING;
               4:       dt = DESC_QUALIFIER;
               default: dt = 8'($urandom);
            endcase
            e.value[15:8] = dt;
            if (dt == DESC_STRING)
               e.value[7:0] = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 4));
         end
         3: e.code = REQ_SET_ADDRESS;
         4: e.code = REQ_SET_CONFIG;
         5: ;
         6: begin
            e.rkind[6:5] = KIND_CLASS;
            e.code = REQ_SET_LINE_CODING;
         end
         7: begin
            e.rkind[6:5] = KIND_CLASS;
            e.code = REQ_GET_LINE_CODING;
         end
         8: begin
            e.rkind[6:5] = KIND_CLASS;
            e.code = REQ_SET_CTRL_LINE;
         end
         9: e.rkind[6:5] = KIND_CLASS;
         default: e.rkind[6:5] = $urandom_range(0, 1) ? KIND_VENDOR : KIND_RESERVED;
      endcase
      return e;
   endfunction

   // drive one event beat, predict its result at acceptance
   task automatic put_event(input ev_rec ev, input logic use_want, input action_rec want);
      action_rec r;
      int        gap;
      gap = (!quiet_tail && calm == 0 && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid          = 1'b1;
      req_bus.event_kind     = ev.kind;
      req_bus.request_kind   = ev.rkind;
      req_bus.request_code   = ev.code;
      req_bus.request_value  = ev.value;
      req_bus.request_length = ev.length;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      r = ep0_respond(ev);
      expected_actions.push_back(use_want ? want : r);
      if (ev.kind != EVT_UNUSED) sent_items++;
      if (calm > 0) calm--;
      else if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 40);
   endtask

   // hold the sender until every expected beat has come back
   task automatic settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_actions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         CSR_DEVICE_DESC_LEN: dev_desc_len = data[7:0];
         CSR_CONFIG_DESC_LEN: cfg_desc_len = data;
         CSR_STRING_COUNT:    str_count    = data[2:0];
         CSR_STRING_LEN_A:    str_len[0]   = data[7:0];
         CSR_STRING_LEN_B:    str_len[1]   = data[7:0];
         CSR_STRING_LEN_C:    str_len[2]   = data[7:0];
         CSR_STRING_LEN_D:    str_len[3]   = data[7:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [7:0] d, input logic [15:0] c,
                                 input logic [2:0] n, input logic [7:0] la,
                                 input logic [7:0] lb, input logic [7:0] lc,
                                 input logic [7:0] ld);
      settle();
      write_reg(CSR_DEVICE_DESC_LEN, {8'd0, d});
      write_reg(CSR_CONFIG_DESC_LEN, c);
      write_reg(CSR_STRING_COUNT, {13'd0, n});
      write_reg(CSR_STRING_LEN_A, {8'd0, la});
      write_reg(CSR_STRING_LEN_B, {8'd0, lb});
      write_reg(CSR_STRING_LEN_C, {8'd0, lc});
      write_reg(CSR_STRING_LEN_D, {8'd0, ld});
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // one control transfer: setup, IN chunks, status; sometimes interrupted
   task automatic run_transfer();
      int chunks;
      put_event(pick_request(), 1'b0, '0);
      chunks = 0;
      while (ctl_phase == PH_SEND && chunks < 12) begin
         if ($urandom_range(0, 15) == 0) put_event(pick_request(), 1'b0, '0);
         put_event(random_event(EVT_IN_DONE), 1'b0, '0);
         chunks++;
      end
      // long transfers are cut short by a bus reset
      if (ctl_phase == PH_SEND) put_event(random_event(EVT_BUS_RESET), 1'b0, '0);
      else if (ctl_phase == PH_RECV) put_event(random_event(EVT_IN_DONE), 1'b0, '0);
   endtask

   task automatic run_random(input int count);
      int goal;
      goal = sent_items + count;
      while (sent_items < goal) begin
         if ($urandom_range(0, 5) == 0)
            put_event(random_event(2'($urandom_range(0, 3))), 1'b0, '0);
         else
            run_transfer();
      end
   endtask

   task automatic check_field(input string nm, input int unsigned w, input int unsigned g);
      if (w !== g) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, w, g);
         mismatches++;
      end
   endtask

   // result side: random stall bursts, none in the tail
   initial begin : rsp_ready_gen
      int hold;
      rsp_bus.ready = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (quiet_tail) begin
            rsp_bus.ready = 1'b1;
         end else if (hold == 0) begin
            if ($urandom_range(0, 2) != 0) begin
               rsp_bus.ready = 1'b1;
               hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
            end else begin
               rsp_bus.ready = 1'b0;
               hold = $urandom_range(1, 14);
            end
         end
         if (hold > 0) hold--;
      end
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin : take_result
      action_rec want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_actions.size() == 0) begin
            $display("%0t: result beat with nothing expected, action %0d", $time, rsp_bus.action);
            mismatches++;
         end else begin
            want = expected_actions.pop_front();
            check_field("action", want.act, rsp_bus.action);
            check_field("data_source", want.src, rsp_bus.data_source);
            check_field("string_index", want.str, rsp_bus.string_index);
            check_field("data_offset", want.off, rsp_bus.data_offset);
            check_field("packet_len", want.len, rsp_bus.packet_len);
            check_field("device_address", want.addr, rsp_bus.device_address);
            check_field("device_state", want.dstate, rsp_bus.device_state);
            check_field("configured", want.cfg, rsp_bus.configured);
            check_field("dtr", want.dtr, rsp_bus.dtr);
            check_field("rts", want.rts, rsp_bus.rts);
            checked_beats++;
            if (want.act <= ACTION_ARM_SETUP) action_seen[want.act]++;
         end
      end
   end

   initial begin : stimulus
      dir_row row;
      int     w;
      // known values on every input from the start
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = '0;
      csr_wdata              = '0;
      req_bus.valid          = 1'b0;
      req_bus.event_kind     = '0;
      req_bus.request_kind   = '0;
      req_bus.request_code   = '0;
      req_bus.request_value  = '0;
      req_bus.request_length = '0;
      mismatches    = 0;
      sent_items    = 0;
      checked_beats = 0;
      calm          = 0;
      quiet_tail    = 1'b0;
      foreach (action_seen[k]) action_seen[k] = 0;

      // model reset
      ctl_phase = PH_IDLE; xfer_total = '0; xfer_sent = '0; xfer_src = SRC_ZLP;
      xfer_str = '0; dev_state = DEV_DEFAULT; dev_addr = '0; cfg_set = 1'b0;
      line_bits = '0;
      dev_desc_len = DEVICE_DESC_LEN_RST; cfg_desc_len = CONFIG_DESC_LEN_RST;
      str_count = STRING_COUNT_RST;
      foreach (str_len[k]) str_len[k] = STRING_LEN_RST;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table: descriptors, chunking, busy, every request and event
      row.has_want = 1'b1;
      row.ev   = ev_of(EVT_SETUP, 8'h80, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'hFFFF);
      row.want = act_of(ACTION_SEND_IN, SRC_DEVICE, 8'd0, 16'd0, 7'd18, 7'd0, DEV_DEFAULT,
                        1'b0, 1'b0, 1'b0);
      directed_rows.push_back(row);
      row.ev   = ev_of(EVT_IN_DONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
      row.want = act_of(ACTION_ARM_SETUP, SRC_ZLP, 8'd0, 16'd0, 7'd0, 7'd0, DEV_DEFAULT,
                        1'b0, 1'b0, 1'b0);
      directed_rows.push_back(row);
      row.ev   = ev_of(EVT_SETUP, 8'h80, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 16'hFFFF);
      row.want = act_of(ACTION_SEND_IN, SRC_CONFIG, 8'd0, 16'd0, 7'd64, 7'd0, DEV_DEFAULT,
                        1'b0, 1'b0, 1'b0);
      directed_rows.push_back(row);
      row.ev   = ev_of(EVT_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000);
      row.want = act_of(ACTION_SEND_IN, SRC_CONFIG, 8'd0, 16'd64, 7'd3, 7'd0, DEV_DEFAULT,
                        1'b0, 1'b0, 1'b0);
      directed_rows.push_back(row);
      // new transmit while sending is dropped
      row.ev   = ev_of(EVT_SETUP, 8'h80, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'h0040);
      row.want = act_of(ACTION_NONE, SRC_ZLP, 8'd0, 16'd0, 7'd0, 7'd0, DEV_DEFAULT,
                        1'b0, 1'b0, 1'b0);
      directed_rows.push_back(row);
      row.ev   = ev_of(EVT_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000);
      row.want = act_of(ACTION_ARM_SETUP, SRC_ZLP, 8'd0, 16'd0, 7'd0, 7'd0, DEV_DEFAULT,
                        1'b0, 1'b0, 1'b0);
      directed_rows.push_back(row);
      row.ev   = ev_of(EVT_SETUP, 8'h80, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'h03}, 16'd255);
      row.want = act_of(ACTION_SEND_IN, SRC_STRING, 8'd3, 16'd0, 7'd4, 7'd0, DEV_DEFAULT,
                        1'b0, 1'b0, 1'b0);
      directed_rows.push_back(row);
      // device qualifier stalls, even mid-transfer
      row.ev   = ev_of(EVT_SETUP, 8'h80, REQ_GET_DESCRIPTOR, {DESC_QUALIFIER, 8'h00}, 16'd10);
      row.want = act_of(ACTION_STALL, SRC_ZLP, 8'd0, 16'd0, 7'd0, 7'd0, DEV_DEFAULT,
                        1'b0, 1'b0, 1'b0);
      directed_rows.push_back(row);
      row.ev   = ev_of(EVT_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000);
      row.want = act_of(ACTION_ARM_SETUP, SRC_ZLP, 8'd0, 16'd0, 7'd0, 7'd0, DEV_DEFAULT,
                        1'b0, 1'b0, 1'b0);
      directed_rows.push_back(row);
      row.ev   = ev_of(EVT_SETUP, 8'h00, REQ_SET_ADDRESS, 16'h007F, 16'h0000);
      row.want = act_of(ACTION_SEND_IN, SRC_ZLP, 8'd0, 16'd0, 7'd0, 7'd127, DEV_ADDRESSED,
                        1'b0, 1'b0, 1'b0);
      directed_rows.push_back(row);
      row.ev   = ev_of(EVT_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000);
      row.want = act_of(ACTION_ARM_SETUP, SRC_ZLP, 8'd0, 16'd0, 7'd0, 7'd127, DEV_ADDRESSED,
                        1'b0, 1'b0, 1'b0);
      directed_rows.push_back(row);

      // remaining rows are checked by the model, all but the bus reset row
      row.has_want = 1'b0;
      row.want     = '0;
      // string index beyond the count, unknown descriptor type
      row.ev = ev_of(EVT_SETUP, 8'h80, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'h04}, 16'd255);
      directed_rows.push_back(row);
      row.ev = ev_of(EVT_SETUP, 8'h80, REQ_GET_DESCRIPTOR, 16'hFFFF, 16'hFFFF);
      directed_rows.push_back(row);
      // address zero drops back to default
      row.ev = ev_of(EVT_SETUP, 8'h00, REQ_SET_ADDRESS, 16'hFF80, 16'h0000);
      directed_rows.push_back(row);
      row.ev = ev_of(EVT_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000);
      directed_rows.push_back(row);
      row.ev = ev_of(EVT_SETUP, 8'h00, REQ_SET_CONFIG, 16'h0001, 16'h0000);
      directed_rows.push_back(row);
      row.ev = ev_of(EVT_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000);
      directed_rows.push_back(row);
      row.ev = ev_of(EVT_SETUP, 8'h21, REQ_SET_CTRL_LINE, 16'h0003, 16'h0000);
      directed_rows.push_back(row);
      row.ev = ev_of(EVT_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000);
      directed_rows.push_back(row);
      row.ev = ev_of(EVT_SETUP, 8'hA1, REQ_GET_LINE_CODING, 16'h0000, 16'h0007);
      directed_rows.push_back(row);
      row.ev = ev_of(EVT_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000);
      directed_rows.push_back(row);
      row.ev = ev_of(EVT_SETUP, 8'h21, REQ_SET_LINE_CODING, 16'h0000, 16'h0007);
      directed_rows.push_back(row);
      // IN complete outside a data-in phase
      row.ev = ev_of(EVT_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000);
      directed_rows.push_back(row);
      // unknown standard request acks, vendor kind is ignored
      row.ev = ev_of(EVT_SETUP, 8'h1F, 8'hFF, 16'h1234, 16'h0000);
      directed_rows.push_back(row);
      row.ev = ev_of(EVT_SETUP, 8'h40, 8'h01, 16'h0000, 16'h0000);
      directed_rows.push_back(row);
      row.ev = ev_of(EVT_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000);
      directed_rows.push_back(row);
      // bus reset keeps the line state
      row.has_want = 1'b1;
      row.ev   = ev_of(EVT_BUS_RESET, 8'h00, 8'h00, 16'h0000, 16'h0000);
      row.want = act_of(ACTION_ARM_SETUP, SRC_ZLP, 8'd0, 16'd0, 7'd0, 7'd0, DEV_DEFAULT,
                        1'b0, 1'b1, 1'b1);
      directed_rows.push_back(row);
      row.has_want = 1'b0;
      row.want     = '0;
      row.ev = ev_of(EVT_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
      directed_rows.push_back(row);

      foreach (directed_rows[k])
         put_event(directed_rows[k].ev, directed_rows[k].has_want, directed_rows[k].want);

      // reset settings
      run_random(120);
      // lower extremes
      apply_settings(8'd0, 16'd0, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      run_random(60);
      // upper extremes, with one full drain midway
      apply_settings(8'd255, 16'hFFFF, 3'(STRING_SLOTS), 8'd255, 8'd255, 8'd255, 8'd255);
      run_random(50);
      settle();
      run_random(50);
      // random middle settings, tail without idling
      apply_settings(8'($urandom_range(1, 254)), 16'($urandom_range(1, 400)),
                     3'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
      run_random(60);
      quiet_tail = 1'b1;
      run_random(60);

      @(negedge clock);
      req_bus.valid = 1'b0;
      for (w = 0; w < 2000 && expected_actions.size() != 0; w++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_actions.size() != 0) begin
         $display("%0t: %0d expected result beats never arrived", $time,
                  expected_actions.size());
         mismatches += expected_actions.size();
      end

      $display("covered %0d events over four register settings, %0d result beats checked",
               sent_items, checked_beats);
      $display("actions: none %0d, send %0d, stall %0d, arm out %0d, arm setup %0d",
               action_seen[0], action_seen[1], action_seen[2], action_seen[3], action_seen[4]);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/ucee_pkg.sv
sv/ucee_req_if.sv
sv/ucee_rsp_if.sv
sv/ucee_front.sv
sv/ucee_queue.sv
sv/ucee_back.sv
sv/usb_control_endpoint_engine_core.sv
verif/tb.sv
